>>> src/haar2d_pkg.sv
// ------------------------------------------------------------------------------------------------
// haar2d_pkg
// Shared constants for the single-level 2-D Haar transform block.
// ------------------------------------------------------------------------------------------------
package haar2d_pkg;

   localparam int MAX_HALF_DEFAULT = 64;

   localparam int PIXEL_W = 8;
   localparam int COEF_W  = 11;
   localparam int BAND_W  = 2;
   localparam int DEST_W  = 7;
   localparam int BPS_W   = 7;
   localparam int MAXV_W  = 8;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKS_PER_SIDE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VALUE       = 1'b1;

   localparam int                  BPS_RESET  = 64;
   localparam logic [MAXV_W-1:0]   MAXV_RESET = 8'd255;

   localparam logic [BAND_W-1:0] BAND_LL = 2'd0;
   localparam logic [BAND_W-1:0] BAND_HL = 2'd1;
   localparam logic [BAND_W-1:0] BAND_LH = 2'd2;
   localparam logic [BAND_W-1:0] BAND_HH = 2'd3;

endpackage

>>> src/haar_2d_single_level.sv
// ------------------------------------------------------------------------------------------------
// haar_2d_single_level
// Streaming single-level 2-D Haar transform over a square grey image in raster order.
// ------------------------------------------------------------------------------------------------
// Pixels enter one per request; each even row is packed two pixels to a word into a line store of
// MAX_HALF words. On the odd-row, odd-column pixel of every 2x2 block the block is latched and four
// coefficients (LL, HL, LH, HH) leave one per cycle while the output is not stalled by rsp_ready,
// through a registered output, each with its doubled sum, quadrant destination and clamped copy.
// Pixels that close no block are taken one per cycle, even while a block drains; a block-closing
// pixel is held until the previous block's HH result loads into the output register, as all
// results share the single result port. The line store word for a block is read on the
// even-column pixel of the odd row and used on the next pixel. Writing blocks_per_side restarts
// the frame.
module haar_2d_single_level
   import haar2d_pkg::*;
#(
   parameter int MAX_HALF = MAX_HALF_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [PIXEL_W-1:0]       req_pixel,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [COEF_W-1:0] rsp_coefficient_x2,
   output logic [BAND_W-1:0]        rsp_band,
   output logic [DEST_W-1:0]        rsp_dest_row,
   output logic [DEST_W-1:0]        rsp_dest_col,
   output logic [PIXEL_W-1:0]       rsp_clipped,
   output logic                     rsp_block_last,
   output logic                     rsp_frame_last,

   input  logic                     csr_write,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CW = (MAX_HALF > 1) ? $clog2(2 * MAX_HALF) : 1;
   localparam int AW = (CW > 1) ? CW - 1 : 1;
   localparam int HALF_RESET = (BPS_RESET > MAX_HALF) ? MAX_HALF : BPS_RESET;

   typedef logic [CW-1:0] count_type;

   // configuration
   count_type             half_ff, half_in;
   logic [MAXV_W-1:0]     maxv_ff, maxv_in;
   logic [BPS_W-1:0]      bps_wr;

   // raster position
   count_type             row_ff, row_in;
   count_type             col_ff, col_in;
   count_type             side_m1;
   logic [CW:0]           side_m1_wide;

   logic [PIXEL_W-1:0]    held_ff, held_in;

   // line store, two pixels per word
   logic [2*PIXEL_W-1:0]  line_store [MAX_HALF];
   logic [2*PIXEL_W-1:0]  line_rd_ff;
   logic [AW-1:0]         line_addr;
   logic                  line_wr;
   logic                  line_rd;

   // latched block
   logic                  blk_valid_ff, blk_valid_in;
   logic [BAND_W-1:0]     band_ff, band_in;
   logic [PIXEL_W-1:0]    pa_ff, pb_ff, pc_ff, pd_ff;
   count_type             bi_ff, bj_ff;
   logic                  flast_ff;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [COEF_W-1:0] coef_ff, coef_in;
   logic [BAND_W-1:0]        rband_ff;
   logic [DEST_W-1:0]        drow_ff, drow_in;
   logic [DEST_W-1:0]        dcol_ff, dcol_in;
   logic [PIXEL_W-1:0]       clip_ff, clip_in;
   logic                     blast_ff, rflast_ff;

   logic                  accept;
   logic                  out_load;
   logic                  blk_done;
   logic                  odd_row, odd_col;
   logic                  col_end, row_end;
   logic                  blk_start;

   logic signed [COEF_W-1:0] sa, sb, sc, sd;
   logic signed [COEF_W-1:0] coef_half;
   logic [CW:0]              row_sum, col_sum;

   assign out_load  = blk_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign blk_done  = out_load && (band_ff == BAND_HH);
   assign req_ready = !blk_valid_ff || blk_done || !(odd_row && odd_col);
   assign accept    = req_valid && req_ready;

   assign odd_row      = row_ff[0];
   assign odd_col      = col_ff[0];
   assign side_m1_wide = {half_ff, 1'b0} - {{CW{1'b0}}, 1'b1};
   assign side_m1      = side_m1_wide[CW-1:0];
   assign col_end      = (col_ff == side_m1);
   assign row_end      = (row_ff == side_m1);
   assign blk_start    = accept && odd_row && odd_col;

   assign line_addr = AW'(col_ff >> 1);
   assign line_wr   = accept && !odd_row && odd_col;
   assign line_rd   = accept && odd_row && !odd_col;

   assign bps_wr = csr_wdata[BPS_W-1:0];

   // configuration and raster counters
   always_comb begin
      half_in = half_ff;
      maxv_in = maxv_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      held_in = held_ff;
      if (accept) begin
         if (!odd_col) begin
            held_in = req_pixel;
         end
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + count_type'(1);
         end else begin
            col_in = col_ff + count_type'(1);
         end
      end
      if (csr_write) begin
         unique case (csr_index)
            CSR_BLOCKS_PER_SIDE: begin
               if (bps_wr == '0) begin
                  half_in = count_type'(1);
               end else if (int'(bps_wr) > MAX_HALF) begin
                  half_in = count_type'(MAX_HALF);
               end else begin
                  half_in = count_type'(bps_wr);
               end
               row_in = '0;
               col_in = '0;
            end
            CSR_MAX_VALUE: begin
               maxv_in = csr_wdata[MAXV_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // coefficient of the current band
   always_comb begin
      sa = COEF_W'(signed'({1'b0, pa_ff}));
      sb = COEF_W'(signed'({1'b0, pb_ff}));
      sc = COEF_W'(signed'({1'b0, pc_ff}));
      sd = COEF_W'(signed'({1'b0, pd_ff}));
      coef_in = sa + (band_ff[1] ? -sb : sb) + (band_ff[0] ? -sc : sc)
              + ((band_ff[0] ^ band_ff[1]) ? -sd : sd);
      coef_half = coef_in >>> 1;
      if (coef_in < 0) begin
         clip_in = '0;
      end else if (coef_half > COEF_W'(signed'({1'b0, maxv_ff}))) begin
         clip_in = maxv_ff;
      end else begin
         clip_in = coef_half[PIXEL_W-1:0];
      end
      row_sum = {1'b0, bi_ff} + (band_ff[1] ? {1'b0, half_ff} : '0);
      col_sum = {1'b0, bj_ff} + (band_ff[0] ? {1'b0, half_ff} : '0);
      drow_in = DEST_W'(row_sum);
      dcol_in = DEST_W'(col_sum);
   end

   always_comb begin
      blk_valid_in = blk_valid_ff;
      band_in      = band_ff;
      if (out_load) begin
         band_in = band_ff + BAND_W'(1);
         if (band_ff == BAND_HH) begin
            blk_valid_in = 1'b0;
         end
      end
      if (blk_start) begin
         blk_valid_in = 1'b1;
         band_in      = BAND_LL;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff      <= count_type'(HALF_RESET);
         maxv_ff      <= MAXV_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         held_ff      <= '0;
         blk_valid_ff <= 1'b0;
         band_ff      <= BAND_LL;
         rsp_valid_ff <= 1'b0;
      end else begin
         half_ff      <= half_in;
         maxv_ff      <= maxv_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         held_ff      <= held_in;
         blk_valid_ff <= blk_valid_in;
         band_ff      <= band_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // line store
   always_ff @(posedge clock) begin
      if (line_wr) begin
         line_store[line_addr] <= {held_ff, req_pixel};
      end
      if (line_rd) begin
         line_rd_ff <= line_store[line_addr];
      end
   end

   // block and output payload
   always_ff @(posedge clock) begin
      if (blk_start) begin
         pa_ff    <= line_rd_ff[2*PIXEL_W-1:PIXEL_W];
         pb_ff    <= line_rd_ff[PIXEL_W-1:0];
         pc_ff    <= held_ff;
         pd_ff    <= req_pixel;
         bi_ff    <= row_ff >> 1;
         bj_ff    <= col_ff >> 1;
         flast_ff <= row_end && col_end;
      end
      if (out_load) begin
         coef_ff   <= coef_in;
         rband_ff  <= band_ff;
         drow_ff   <= drow_in;
         dcol_ff   <= dcol_in;
         clip_ff   <= clip_in;
         blast_ff  <= (band_ff == BAND_HH);
         rflast_ff <= (band_ff == BAND_HH) && flast_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_coefficient_x2 = coef_ff;
   assign rsp_band           = rband_ff;
   assign rsp_dest_row       = drow_ff;
   assign rsp_dest_col       = dcol_ff;
   assign rsp_clipped        = clip_ff;
   assign rsp_block_last     = blast_ff;
   assign rsp_frame_last     = rflast_ff;

endmodule
